>>> hdl/mwm_pkg.sv
// ----------------------------------------------------------------------------
// Mecanum wheel mixer package
// Shared widths, opcodes, transaction types and arithmetic helpers.
// ----------------------------------------------------------------------------
package mwm_pkg;

  // Field and datapath widths
  localparam int AXIS_W     = 16;             // Q2.14 axis and wheel fields
  localparam int WHEEL_W    = AXIS_W + 1;     // sum of three clamped axes
  localparam int MAG_W      = AXIS_W;         // magnitude of a mixed wheel
  localparam int REM_W      = MAG_W + 1;      // divider partial remainder
  localparam int QUO_W      = 15;             // quotient, at most 16384
  localparam int NUM_WHEELS = 4;              // FL, FR, BL, BR
  localparam int DIV_STEPS  = QUO_W;          // one quotient bit per stage

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Accept edge to the edge that takes the result: queue write, divider
  // input register, divider stages, output register, then the result cycle
  localparam int RESULT_LATENCY = 3 + DIV_STEPS + 1;

  // Unit value in Q2.14
  localparam logic signed [AXIS_W-1:0] Q_ONE_S = 16'sd16384;
  localparam logic        [MAG_W-1:0]  Q_ONE_U = 16'd16384;

  // Opcodes
  localparam logic OP_TANK    = 1'b0;
  localparam logic OP_MECANUM = 1'b1;

  typedef logic signed [WHEEL_W-1:0] wheel_t;

  // Mixed wheel set handed from front to back
  typedef struct packed {
    wheel_t [NUM_WHEELS-1:0] wheel;
  } item_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // One divider lane
  typedef struct packed {
    logic             neg;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } lane_t;

  // One divider stage: shared divisor and four lanes
  typedef struct packed {
    logic [MAG_W-1:0]         div;
    lane_t [NUM_WHEELS-1:0]   lane;
  } stage_t;

  // Final wheel commands
  typedef struct packed {
    logic [NUM_WHEELS-1:0][AXIS_W-1:0] wheel;
  } result_t;

  // Saturate an axis to plus or minus one
  function automatic logic signed [AXIS_W-1:0] clamp_unit(
    input logic signed [AXIS_W-1:0] x
  );
    if (x > Q_ONE_S) begin
      return Q_ONE_S;
    end else if (x < -Q_ONE_S) begin
      return -Q_ONE_S;
    end
    return x;
  endfunction

  // Magnitude of a mixed wheel (never above 49152, fits MAG_W)
  function automatic logic [MAG_W-1:0] abs_mag(input logic [WHEEL_W-1:0] w);
    logic [WHEEL_W-1:0] n;
    n = ~w + WHEEL_W'(1);
    return w[WHEEL_W-1] ? n[MAG_W-1:0] : w[MAG_W-1:0];
  endfunction

  // Produce one quotient bit on every lane; the first step skips the doubling
  function automatic stage_t div_step(input stage_t s, input logic first);
    stage_t           o;
    logic [REM_W-1:0] t;
    logic [REM_W-1:0] d;
    o = s;
    d = {1'b0, s.div};
    for (int i = 0; i < NUM_WHEELS; i++) begin
      t = first ? s.lane[i].rem : {s.lane[i].rem[REM_W-2:0], 1'b0};
      if (t >= d) begin
        o.lane[i].rem = t - d;
        o.lane[i].quo = {s.lane[i].quo[QUO_W-2:0], 1'b1};
      end else begin
        o.lane[i].rem = t;
        o.lane[i].quo = {s.lane[i].quo[QUO_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

endpackage

>>> hdl/mwm_front.sv
// ----------------------------------------------------------------------------
// Mecanum wheel mixer front end
// Accepts drive requests, clamps the axes and mixes them into four wheels.
// ----------------------------------------------------------------------------
module mwm_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_opcode,
  input  logic signed [mwm_pkg::AXIS_W-1:0]   in_axis_a,
  input  logic signed [mwm_pkg::AXIS_W-1:0]   in_axis_b,
  input  logic signed [mwm_pkg::AXIS_W-1:0]   in_axis_c,
  input  mwm_pkg::qstat_t                     qstat,
  output logic                                push,
  output mwm_pkg::item_t                      push_item
);

  logic                               front_valid_r;
  logic                               front_valid_nxt;
  mwm_pkg::item_t                     item_r;
  mwm_pkg::item_t                     item_nxt;
  logic                               accept;
  logic signed [mwm_pkg::AXIS_W-1:0]  ac;
  logic signed [mwm_pkg::AXIS_W-1:0]  bc;
  logic signed [mwm_pkg::AXIS_W-1:0]  cc;
  mwm_pkg::wheel_t                    a;
  mwm_pkg::wheel_t                    b;
  mwm_pkg::wheel_t                    c;

  // Hold off while in reset or while the held transaction cannot move on
  assign busy   = ~rst_n | (front_valid_r & qstat.full);
  assign accept = start & ~busy;
  assign push   = front_valid_r & ~qstat.full;

  // Clamp and mix
  always_comb begin
    ac = mwm_pkg::clamp_unit(in_axis_a);
    bc = mwm_pkg::clamp_unit(in_axis_b);
    cc = mwm_pkg::clamp_unit(in_axis_c);
    a  = {ac[mwm_pkg::AXIS_W-1], ac};
    b  = {bc[mwm_pkg::AXIS_W-1], bc};
    c  = {cc[mwm_pkg::AXIS_W-1], cc};
    case (in_opcode)
      mwm_pkg::OP_TANK: begin
        item_nxt.wheel[0] = a;
        item_nxt.wheel[1] = b;
        item_nxt.wheel[2] = a;
        item_nxt.wheel[3] = b;
      end
      mwm_pkg::OP_MECANUM: begin
        item_nxt.wheel[0] = a + b + c;
        item_nxt.wheel[1] = a - b - c;
        item_nxt.wheel[2] = a - b + c;
        item_nxt.wheel[3] = a + b - c;
      end
      default: begin
        item_nxt = '0;
      end
    endcase
  end

  // Track occupancy of the front register
  always_comb begin
    if (accept) begin
      front_valid_nxt = 1'b1;
    end else if (push) begin
      front_valid_nxt = 1'b0;
    end else begin
      front_valid_nxt = front_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  // Capture the mixed wheels on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign push_item = item_r;

endmodule

>>> hdl/mwm_queue.sv
// ----------------------------------------------------------------------------
// Mecanum wheel mixer queue
// Short register FIFO that decouples the front end from the divider back end.
// ----------------------------------------------------------------------------
module mwm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mwm_pkg::item_t  push_item,
  input  logic            pop,
  output mwm_pkg::item_t  pop_item,
  output mwm_pkg::qstat_t qstat
);

  mwm_pkg::item_t                 mem_r [mwm_pkg::QUEUE_DEPTH];
  logic [mwm_pkg::PTR_W-1:0]      wr_ptr_r;
  logic [mwm_pkg::PTR_W-1:0]      rd_ptr_r;
  logic [mwm_pkg::CNT_W-1:0]      count_r;
  logic [mwm_pkg::CNT_W-1:0]      count_nxt;

  assign count_nxt   = count_r + mwm_pkg::CNT_W'(push) - mwm_pkg::CNT_W'(pop);
  assign qstat.full  = (count_r == mwm_pkg::CNT_W'(mwm_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);
  assign pop_item    = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + mwm_pkg::PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + mwm_pkg::PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  // Store the pushed transaction
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> hdl/mwm_back.sv
// ----------------------------------------------------------------------------
// Mecanum wheel mixer back end
// Finds the largest wheel magnitude and normalizes through a bit-per-stage
// pipelined divider, then registers the signed wheel commands.
// ----------------------------------------------------------------------------
module mwm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  input  mwm_pkg::item_t   item,
  output logic             res_valid,
  output mwm_pkg::result_t res
);

  logic [mwm_pkg::NUM_WHEELS-1:0][mwm_pkg::MAG_W-1:0] mag;
  logic [mwm_pkg::MAG_W-1:0]  max01;
  logic [mwm_pkg::MAG_W-1:0]  max23;
  logic [mwm_pkg::MAG_W-1:0]  max_all;
  mwm_pkg::stage_t            st_in;
  mwm_pkg::stage_t            stg_r [mwm_pkg::DIV_STEPS+1];
  logic [mwm_pkg::DIV_STEPS:0] vld_r;
  logic                       res_valid_r;
  mwm_pkg::result_t           res_r;
  mwm_pkg::result_t           res_nxt;
  logic [mwm_pkg::AXIS_W-1:0] q;

  // Take magnitudes and pick the divisor; unit divisor passes wheels through
  always_comb begin
    for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) begin
      mag[i] = mwm_pkg::abs_mag(item.wheel[i]);
    end
    max01   = (mag[0] > mag[1]) ? mag[0] : mag[1];
    max23   = (mag[2] > mag[3]) ? mag[2] : mag[3];
    max_all = (max01 > max23) ? max01 : max23;
    st_in.div = (max_all > mwm_pkg::Q_ONE_U) ? max_all : mwm_pkg::Q_ONE_U;
    for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) begin
      st_in.lane[i].neg = item.wheel[i][mwm_pkg::WHEEL_W-1];
      st_in.lane[i].rem = {1'b0, mag[i]};
      st_in.lane[i].quo = '0;
    end
  end

  // Advance the valid bits along the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[mwm_pkg::DIV_STEPS-1:0], item_valid};
      res_valid_r <= vld_r[mwm_pkg::DIV_STEPS];
    end
  end

  // Divider stages, one quotient bit each
  always_ff @(posedge clk) begin
    stg_r[0] <= st_in;
    for (int k = 0; k < mwm_pkg::DIV_STEPS; k++) begin
      stg_r[k+1] <= mwm_pkg::div_step(stg_r[k], k == 0);
    end
  end

  // Restore the sign of each quotient
  always_comb begin
    for (int i = 0; i < mwm_pkg::NUM_WHEELS; i++) begin
      q = {1'b0, stg_r[mwm_pkg::DIV_STEPS].lane[i].quo};
      res_nxt.wheel[i] = stg_r[mwm_pkg::DIV_STEPS].lane[i].neg ?
                         (~q + mwm_pkg::AXIS_W'(1)) : q;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

>>> hdl/mecanum_wheel_mixer.sv
// ----------------------------------------------------------------------------
// Mecanum wheel mixer
// Turns a tank or mecanum drive request into four normalized wheel commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive start high with in_opcode and the three Q2.14 axes; the
//   transaction is taken at a rising edge where start is high and busy low.
//   Opcode tank uses axis_a as left and axis_b as right power; opcode
//   mecanum uses forward, strafe and rotate.
//   Output: out_valid is high for one cycle with the four wheel commands
//   (front-left, front-right, back-left, back-right), each within +-16384.
//   The receiver cannot stall; results leave in request order.
//   Throughput: one request per clock. The back end never stalls, so busy
//   stays low after reset and the queue never fills.
//   Path: from the accepting edge a request passes through the queue, the
//   magnitude search into the divider input register, the normalizing
//   divider (one quotient bit per stage) and the output register, which
//   raises out_valid.
//   Reset: rst_n low holds busy high and drops every transaction in flight.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_opcode,
  input  logic signed [mwm_pkg::AXIS_W-1:0] in_axis_a,
  input  logic signed [mwm_pkg::AXIS_W-1:0] in_axis_b,
  input  logic signed [mwm_pkg::AXIS_W-1:0] in_axis_c,
  output logic                              out_valid,
  output logic signed [mwm_pkg::AXIS_W-1:0] out_front_left,
  output logic signed [mwm_pkg::AXIS_W-1:0] out_front_right,
  output logic signed [mwm_pkg::AXIS_W-1:0] out_back_left,
  output logic signed [mwm_pkg::AXIS_W-1:0] out_back_right
);

  mwm_pkg::qstat_t  qstat;
  logic             push;
  mwm_pkg::item_t   push_item;
  logic             pop;
  mwm_pkg::item_t   pop_item;
  mwm_pkg::result_t res;

  // Back end always takes the head of the queue
  assign pop = ~qstat.empty;

  mwm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_opcode (in_opcode),
    .in_axis_a (in_axis_a),
    .in_axis_b (in_axis_b),
    .in_axis_c (in_axis_c),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  mwm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .qstat     (qstat)
  );

  mwm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (pop),
    .item       (pop_item),
    .res_valid  (out_valid),
    .res        (res)
  );

  assign out_front_left  = res.wheel[0];
  assign out_front_right = res.wheel[1];
  assign out_back_left   = res.wheel[2];
  assign out_back_right  = res.wheel[3];

endmodule

>>> hdl/mwm_checker.sv
// ----------------------------------------------------------------------------
// Mecanum wheel mixer checker
// Port-level assertions on latency, stalls and wheel command values.
// ----------------------------------------------------------------------------
module mwm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              in_opcode,
  input logic                              out_valid,
  input logic signed [mwm_pkg::AXIS_W-1:0] out_front_left,
  input logic signed [mwm_pkg::AXIS_W-1:0] out_front_right,
  input logic signed [mwm_pkg::AXIS_W-1:0] out_back_left,
  input logic signed [mwm_pkg::AXIS_W-1:0] out_back_right
);

  // Every transaction gives exactly one result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(start && !busy, mwm_pkg::RESULT_LATENCY))
    else $error("result strobe does not match accepted transaction");

  // Back end never stalls, so the front never holds off after reset
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy asserted outside reset");

  // Wheel commands stay within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_front_left  <= 16'sd16384 && out_front_left  >= -16'sd16384 &&
      out_front_right <= 16'sd16384 && out_front_right >= -16'sd16384 &&
      out_back_left   <= 16'sd16384 && out_back_left   >= -16'sd16384 &&
      out_back_right  <= 16'sd16384 && out_back_right  >= -16'sd16384)
    else $error("wheel command out of range");

  // Tank drive mirrors left to even wheels and right to odd wheels
  a_tank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($past(in_opcode, mwm_pkg::RESULT_LATENCY) == mwm_pkg::OP_TANK) |->
      out_front_left == out_back_left && out_front_right == out_back_right)
    else $error("tank result not mirrored");

endmodule

bind mecanum_wheel_mixer mwm_checker u_mwm_checker (.*);

>>> tb/mwm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mecanum wheel mixer checker
// Watches the request and result channels, predicts the four wheel commands
// for every accepted request and compares each result in order.
// ----------------------------------------------------------------------------
module mwm_scoreboard (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic                               in_opcode,
  input  logic signed [mwm_pkg::AXIS_W-1:0]  in_axis_a,
  input  logic signed [mwm_pkg::AXIS_W-1:0]  in_axis_b,
  input  logic signed [mwm_pkg::AXIS_W-1:0]  in_axis_c,
  input  logic                               out_valid,
  input  logic signed [mwm_pkg::AXIS_W-1:0]  out_front_left,
  input  logic signed [mwm_pkg::AXIS_W-1:0]  out_front_right,
  input  logic signed [mwm_pkg::AXIS_W-1:0]  out_back_left,
  input  logic signed [mwm_pkg::AXIS_W-1:0]  out_back_right,
  output int                                 fail_count,
  output int                                 pending_count,
  output int                                 request_count,
  output int                                 mecanum_count,
  output int                                 scaled_count,
  output int                                 result_count
);

  localparam int UNIT = 16384;

  typedef logic signed [mwm_pkg::AXIS_W-1:0] axis_t;

  typedef struct packed {
    axis_t fl;
    axis_t fr;
    axis_t bl;
    axis_t br;
  } wheel_set_t;

  // Wheel sets still owed by the block, oldest first
  wheel_set_t owed_wheels[$];

  // Saturate one Q2.14 axis to plus or minus one
  function automatic int saturate_unit(input axis_t x);
    int v;
    v = x;
    if (v > UNIT) begin
      return UNIT;
    end
    if (v < -UNIT) begin
      return -UNIT;
    end
    return v;
  endfunction

  // Compute the wheel commands for one drive request
  function automatic wheel_set_t mix_wheels(
    input  logic  op,
    input  axis_t a_raw,
    input  axis_t b_raw,
    input  axis_t c_raw,
    output bit    scaled
  );
    int         a;
    int         b;
    int         c;
    int         peak;
    int         mag;
    int         w[4];
    wheel_set_t ws;
    a      = saturate_unit(a_raw);
    b      = saturate_unit(b_raw);
    c      = saturate_unit(c_raw);
    scaled = 1'b0;
    if (op == mwm_pkg::OP_TANK) begin
      w = '{a, b, a, b};
    end else begin
      w    = '{a + b + c, a - b - c, a - b + c, a + b - c};
      peak = 0;
      foreach (w[i]) begin
        mag = (w[i] < 0) ? -w[i] : w[i];
        if (mag > peak) begin
          peak = mag;
        end
      end
      // Normalize by the largest magnitude; int division truncates toward zero
      if (peak > UNIT) begin
        scaled = 1'b1;
        foreach (w[i]) begin
          w[i] = (w[i] * UNIT) / peak;
        end
      end
    end
    ws.fl = axis_t'(w[0]);
    ws.fr = axis_t'(w[1]);
    ws.bl = axis_t'(w[2]);
    ws.br = axis_t'(w[3]);
    return ws;
  endfunction

  // Compare results first, then log the new request transaction
  always @(posedge clk) begin
    wheel_set_t got;
    wheel_set_t want;
    bit         scaled;
    if (!rst_n) begin
      owed_wheels.delete();
      pending_count <= 0;
    end else begin
      if (out_valid) begin
        got = '{fl: out_front_left, fr: out_front_right,
                bl: out_back_left, br: out_back_right};
        result_count <= result_count + 1;
        if (owed_wheels.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) begin
            $display("[%0t] unexpected result fl=%0d fr=%0d bl=%0d br=%0d",
                     $realtime, got.fl, got.fr, got.bl, got.br);
          end
        end else begin
          want = owed_wheels.pop_front();
          if (got != want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) begin
              $display("[%0t] mismatch fl %0d/%0d fr %0d/%0d bl %0d/%0d br %0d/%0d (exp/act)",
                       $realtime, want.fl, got.fl, want.fr, got.fr,
                       want.bl, got.bl, want.br, got.br);
            end
          end
        end
      end
      if (start && !busy) begin
        owed_wheels.push_back(mix_wheels(in_opcode, in_axis_a, in_axis_b,
                                         in_axis_c, scaled));
        request_count <= request_count + 1;
        if (in_opcode == mwm_pkg::OP_MECANUM) begin
          mecanum_count <= mecanum_count + 1;
        end
        if (scaled) begin
          scaled_count <= scaled_count + 1;
        end
      end
      pending_count <= owed_wheels.size();
    end
  end

endmodule

>>> tb/tb_mecanum_wheel_mixer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mecanum wheel mixer testbench
// Drives directed and random tank and mecanum requests under three pacing
// phases; the checker predicts and compares every wheel set.
// ----------------------------------------------------------------------------
module tb_mecanum_wheel_mixer;

  localparam int RANDOM_ITEMS   = 1400;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic signed [mwm_pkg::AXIS_W-1:0] axis_t;

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  start     = 1'b0;
  logic  in_opcode = mwm_pkg::OP_TANK;
  axis_t in_axis_a = '0;
  axis_t in_axis_b = '0;
  axis_t in_axis_c = '0;
  logic  busy;
  logic  out_valid;
  axis_t out_front_left;
  axis_t out_front_right;
  axis_t out_back_left;
  axis_t out_back_right;

  int fail_count;
  int pending_count;
  int request_count;
  int mecanum_count;
  int scaled_count;
  int result_count;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  mecanum_wheel_mixer uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_axis_a       (in_axis_a),
    .in_axis_b       (in_axis_b),
    .in_axis_c       (in_axis_c),
    .out_valid       (out_valid),
    .out_front_left  (out_front_left),
    .out_front_right (out_front_right),
    .out_back_left   (out_back_left),
    .out_back_right  (out_back_right)
  );

  mwm_scoreboard u_scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_axis_a       (in_axis_a),
    .in_axis_b       (in_axis_b),
    .in_axis_c       (in_axis_c),
    .out_valid       (out_valid),
    .out_front_left  (out_front_left),
    .out_front_right (out_front_right),
    .out_back_left   (out_back_left),
    .out_back_right  (out_back_right),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .request_count   (request_count),
    .mecanum_count   (mecanum_count),
    .scaled_count    (scaled_count),
    .result_count    (result_count)
  );

  // Abort when no transaction moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Pick one axis value: full range, unit range, small, or a clamp boundary
  function automatic axis_t pick_axis();
    axis_t edges[11];
    edges = '{16'sh8000, -16'sd16385, -16'sd16384, -16'sd16383, -16'sd1,
              16'sd0, 16'sd1, 16'sd16383, 16'sd16384, 16'sd16385, 16'sh7FFF};
    case ($urandom_range(3))
      0: begin
        return axis_t'($urandom);
      end
      1: begin
        return axis_t'($urandom_range(32768) - 16384);
      end
      2: begin
        return axis_t'($urandom_range(8192) - 4096);
      end
      default: begin
        return edges[$urandom_range(10)];
      end
    endcase
  endfunction

  // Present one request and hold it until the block takes the transaction
  task automatic send_request(input logic op, input axis_t a, input axis_t b,
                              input axis_t c);
    @(negedge clk);
    start     <= 1'b1;
    in_opcode <= op;
    in_axis_a <= a;
    in_axis_b <= b;
    in_axis_c <= c;
    while (busy) begin
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  // Idle the sender cycle by cycle with junk on the idle fields
  task automatic sender_gap(input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start     <= 1'b0;
      in_opcode <= 1'($urandom_range(1));
      in_axis_a <= axis_t'($urandom);
      in_axis_b <= axis_t'($urandom);
      in_axis_c <= axis_t'($urandom);
    end
  endtask

  initial begin
    int idle_pct;
    repeat (10) begin
      @(posedge clk);
    end
    @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 21 : (phase == 1) ? 61 : 0;
      if (phase == 0) begin
        // Tank: zero, unit extremes, clamping, rotate ignored
        send_request(mwm_pkg::OP_TANK, 16'sd0, 16'sd0, 16'sd0);
        send_request(mwm_pkg::OP_TANK, 16'sd16384, -16'sd16384, 16'sd12345);
        send_request(mwm_pkg::OP_TANK, 16'sh7FFF, 16'sh8000, 16'sh8000);
        send_request(mwm_pkg::OP_TANK, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
        send_request(mwm_pkg::OP_TANK, 16'sd16385, -16'sd16385, 16'sd0);
        send_request(mwm_pkg::OP_TANK, -16'sd1, 16'sd1, -16'sd7);
        // Mecanum: pass-through, the unit boundary and just beyond it
        send_request(mwm_pkg::OP_MECANUM, 16'sd0, 16'sd0, 16'sd0);
        send_request(mwm_pkg::OP_MECANUM, 16'sd16384, 16'sd0, 16'sd0);
        send_request(mwm_pkg::OP_MECANUM, 16'sd8192, 16'sd8192, 16'sd0);
        send_request(mwm_pkg::OP_MECANUM, 16'sd8192, 16'sd8193, 16'sd0);
        // Mecanum: full-scale and clamped axes, normalization needed
        send_request(mwm_pkg::OP_MECANUM, 16'sd16384, 16'sd16384, 16'sd16384);
        send_request(mwm_pkg::OP_MECANUM, -16'sd16384, -16'sd16384, -16'sd16384);
        send_request(mwm_pkg::OP_MECANUM, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_request(mwm_pkg::OP_MECANUM, 16'sh8000, 16'sh8000, 16'sh8000);
        send_request(mwm_pkg::OP_MECANUM, 16'sd16384, -16'sd16384, 16'sd16384);
        // Mecanum: inexact quotients, truncation on both signs, unit-boundary sums
        send_request(mwm_pkg::OP_MECANUM, 16'sd12000, 16'sd7000, -16'sd5000);
        send_request(mwm_pkg::OP_MECANUM, -16'sd12000, 16'sd7000, 16'sd5000);
        send_request(mwm_pkg::OP_MECANUM, 16'sd5461, 16'sd5461, 16'sd5462);
        send_request(mwm_pkg::OP_MECANUM, 16'sd0, 16'sd0, 16'sh7FFF);
        send_request(mwm_pkg::OP_MECANUM, 16'sd0, 16'sh8000, 16'sd0);
      end
      repeat (RANDOM_ITEMS / 3) begin
        sender_gap(idle_pct);
        send_request(1'($urandom_range(1)), pick_axis(), pick_axis(), pick_axis());
      end
    end

    // Drain: wait for every owed result, then keep watching for stray results
    @(negedge clk);
    start <= 1'b0;
    while (pending_count != 0) begin
      @(negedge clk);
    end
    repeat (mwm_pkg::RESULT_LATENCY + 4) begin
      @(negedge clk);
    end

    $display("Covered %0d requests (%0d mecanum, %0d normalized) and %0d results",
             request_count, mecanum_count, scaled_count, result_count);
    $display("over sender idle rates of 21, 61 and 0 percent; %0d mismatches",
             fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/mwm_pkg.sv
hdl/mwm_front.sv
hdl/mwm_queue.sv
hdl/mwm_back.sv
hdl/mecanum_wheel_mixer.sv
hdl/mwm_checker.sv
tb/mwm_checker.sv
tb/tb_mecanum_wheel_mixer.sv
